### rtl/core/b58d_pkg.sv
// Shared types, constants and the character classifier for the Base58 decoder.
// No dependencies; every other file of the decoder imports this package.
package b58d_pkg;

    localparam int OUT_BYTES = 32;
    localparam int MAX_CHARS = 44;
    localparam int MIN_CHARS = 32;
    localparam int VAL_W     = 8 * OUT_BYTES;
    localparam int ACC_W     = VAL_W + 2;
    localparam int CNT_W     = 6;
    localparam int DIGIT_W   = 6;
    localparam int BEAT_W    = $clog2(OUT_BYTES);

    localparam logic [CNT_W-1:0] CNT_SAT   = '1;
    localparam logic [7:0]       CHAR_ONE  = 8'h31;
    localparam logic [CNT_W-1:0] MIN_COUNT = CNT_W'(MIN_CHARS);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_CHARS);
    localparam logic [CNT_W-1:0] ALL_BYTES = CNT_W'(OUT_BYTES);
    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(OUT_BYTES - 1);

    typedef struct packed {
        logic [7:0] text_char;
        logic       char_last;
    } char_beat_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       decode_ok;
        logic       byte_last;
    } byte_beat_t;

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               bad;
        logic               is_one;
        logic               last;
    } cls_t;

    // A finished string handed from the accumulator to the emitter.
    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] lead;
        logic             bad;
    } res_t;

    // Maps a character to its digit; bad is set outside the alphabet.
    function automatic cls_t classify(input char_beat_t c);
        cls_t r;
        logic [7:0] ch;
        ch       = c.text_char;
        r.digit  = '0;
        r.bad    = 1'b0;
        r.is_one = (ch == CHAR_ONE);
        r.last   = c.char_last;
        if (ch >= 8'h31 && ch <= 8'h39)
            r.digit = DIGIT_W'(ch - 8'h31);
        else if (ch >= 8'h41 && ch <= 8'h48)
            r.digit = DIGIT_W'(ch - 8'h41 + 8'd9);
        else if (ch >= 8'h4a && ch <= 8'h4e)
            r.digit = DIGIT_W'(ch - 8'h4a + 8'd17);
        else if (ch >= 8'h50 && ch <= 8'h5a)
            r.digit = DIGIT_W'(ch - 8'h50 + 8'd22);
        else if (ch >= 8'h61 && ch <= 8'h6b)
            r.digit = DIGIT_W'(ch - 8'h61 + 8'd33);
        else if (ch >= 8'h6d && ch <= 8'h7a)
            r.digit = DIGIT_W'(ch - 8'h6d + 8'd44);
        else
            r.bad = 1'b1;
        return r;
    endfunction

endpackage

### rtl/core/b58d_front.sv
// Front end: accepts character beats and classifies them into digits.
// Depends on b58d_pkg.
module b58d_front (
    input  b58d_pkg::char_beat_t char_beat,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  logic                 q_full,
    output logic                 q_push,
    output b58d_pkg::cls_t       q_wdata
);
    import b58d_pkg::*;

    assign char_stall = q_full;
    assign q_push     = char_valid & ~q_full;
    assign q_wdata    = classify(char_beat);

endmodule

### rtl/core/b58d_queue.sv
// Two-entry queue of classified characters between front end and accumulator.
// Depends on b58d_pkg.
module b58d_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b58d_pkg::cls_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output b58d_pkg::cls_t rdata
);
    import b58d_pkg::*;

    cls_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/b58d_back.sv
// Accumulator: value = value*58 + digit per character, with length and run counts.
// Depends on b58d_pkg; hands finished strings to b58d_emit.
module b58d_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  b58d_pkg::cls_t q_rdata,
    output logic           q_pop,
    output logic           res_valid,
    output b58d_pkg::res_t res,
    input  logic           res_take
);
    import b58d_pkg::*;

    logic [ACC_W-1:0] value_reg, value_next, value_upd;
    logic [CNT_W-1:0] count_reg, count_next, count_upd;
    logic [CNT_W-1:0] lead_reg, lead_next, lead_upd;
    logic             still_reg, still_next, still_upd;
    logic             bad_reg, bad_next, bad_upd;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A last character waits while the previous result is still held.
    assign q_pop = q_valid & (~q_rdata.last | ~res_valid_reg | res_take);

    always_comb
    begin
        // 58 = 32 + 16 + 8 + 2
        value_upd = (value_reg << 5) + (value_reg << 4) + (value_reg << 3)
                  + (value_reg << 1) + ACC_W'(q_rdata.digit);
        count_upd = (count_reg == CNT_SAT) ? count_reg : count_reg + 1'b1;
        still_upd = still_reg & q_rdata.is_one;
        lead_upd  = (still_upd && lead_reg != CNT_SAT) ? lead_reg + 1'b1 : lead_reg;
        bad_upd   = bad_reg | q_rdata.bad;

        value_next     = value_reg;
        count_next     = count_reg;
        lead_next      = lead_reg;
        still_next     = still_reg;
        bad_next       = bad_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg & ~res_take;

        if (q_pop)
        begin
            if (q_rdata.last)
            begin
                res_next.value = value_upd;
                res_next.count = count_upd;
                res_next.lead  = lead_upd;
                res_next.bad   = bad_upd;
                res_valid_next = 1'b1;
                value_next     = '0;
                count_next     = '0;
                lead_next      = '0;
                still_next     = 1'b1;
                bad_next       = 1'b0;
            end
            else
            begin
                value_next = value_upd;
                count_next = count_upd;
                lead_next  = lead_upd;
                still_next = still_upd;
                bad_next   = bad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg     <= '0;
            count_reg     <= '0;
            lead_reg      <= '0;
            still_reg     <= 1'b1;
            bad_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            value_reg     <= value_next;
            count_reg     <= count_next;
            lead_reg      <= lead_next;
            still_reg     <= still_next;
            bad_reg       <= bad_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### rtl/core/b58d_emit.sv
// Result checker and byte emitter: validates a finished string, then shifts out bytes.
// Depends on b58d_pkg; fed by b58d_back.
module b58d_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  b58d_pkg::res_t       res,
    output logic                 res_take,
    output b58d_pkg::byte_beat_t byte_beat,
    output logic                 byte_valid,
    input  logic                 byte_stall
);
    import b58d_pkg::*;

    logic [VAL_W-1:0]  sr_reg, sr_next;
    logic              busy_reg, busy_next;
    logic              ok_reg, ok_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic [OUT_BYTES-1:0] zero_byte;
    logic              canon_ok, res_ok, beat_done, fin;

    assign byte_valid          = busy_reg;
    assign byte_beat.data_byte = sr_reg[VAL_W-1 -: 8];
    assign byte_beat.decode_ok = ok_reg;
    assign byte_beat.byte_last = ~ok_reg | (beat_reg == LAST_BEAT);

    assign beat_done = busy_reg & ~byte_stall;
    assign fin       = beat_done & byte_beat.byte_last;
    assign res_take  = res_valid & (~busy_reg | fin);

    // Canonical form: the first lead bytes are zero and the byte after them is
    // not, which also covers the case with no leading ones.
    always_comb
    begin
        for (int i = 0; i < OUT_BYTES; i++)
        begin
            zero_byte[i] = (res.value[VAL_W-1-8*i -: 8] == 8'd0);
        end
        canon_ok = (res.lead <= ALL_BYTES);
        for (int i = 0; i < OUT_BYTES; i++)
        begin
            if (CNT_W'(i) < res.lead && !zero_byte[i])
                canon_ok = 1'b0;
            if (CNT_W'(i) == res.lead && zero_byte[i])
                canon_ok = 1'b0;
        end
        res_ok = canon_ok && !res.bad
              && res.count >= MIN_COUNT && res.count <= MAX_COUNT
              && res.value[ACC_W-1:VAL_W] == 2'd0;
    end

    always_comb
    begin
        sr_next   = sr_reg;
        busy_next = busy_reg;
        ok_next   = ok_reg;
        beat_next = beat_reg;
        if (res_take)
        begin
            sr_next   = res_ok ? res.value[VAL_W-1:0] : '0;
            ok_next   = res_ok;
            busy_next = 1'b1;
            beat_next = '0;
        end
        else if (fin)
        begin
            busy_next = 1'b0;
        end
        else if (beat_done)
        begin
            sr_next   = sr_reg << 8;
            beat_next = beat_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ok_reg   <= 1'b0;
            beat_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ok_reg   <= ok_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

endmodule

### rtl/core/base58_decode_32_byte_top.sv
// Base58 decoder for 256-bit values: one character beat in, 32 byte beats or one failure beat out.
// Depends on b58d_pkg, b58d_front, b58d_queue, b58d_back and b58d_emit.
// Throughput: one character per cycle unless stalled, set by the multiply-by-58 accumulator.
// A finished string is registered in b58d_back, then loaded into b58d_emit's shift register.
// A string's 32 output beats drain while the next string accumulates; a last character stalls
// only if the previous result has not started draining. Result, shift and queue data skip reset.
module base58_decode_32_byte_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b58d_pkg::char_beat_t char_beat,
    input  logic                 char_valid,
    output logic                 char_stall,
    output b58d_pkg::byte_beat_t byte_beat,
    output logic                 byte_valid,
    input  logic                 byte_stall
);
    import b58d_pkg::*;

    // The front end classifies each character on the way into a two-entry
    // queue, so the input stalls only when the queue is full.
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cls_t q_wdata;
    cls_t q_rdata;

    // A finished string sits in a holding register in the accumulator until
    // the emitter is free to check it and start sending its bytes.
    logic res_valid;
    logic res_take;
    res_t res;

    b58d_front u_front (
        .char_beat  (char_beat),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    b58d_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    b58d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // The emitter drives the output beat straight from its registers.
    b58d_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take),
        .byte_beat  (byte_beat),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for base58_decode_32_byte_top: drives Base58 strings, predicts bytes.
// Depends on b58d_pkg for the beat types and size constants, and on the decoder RTL.
module tb;

    import b58d_pkg::*;

    // Characters of the alphabet in digit order; the index of a character is its digit value.
    string b58_alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    // Kinds of string that the random part draws from. The first of them is also forced at the
    // start of the first random pass so that the all-zero value is always seen early.
    typedef enum int {
        TK_ZERO,
        TK_MAX,
        TK_OVER,
        TK_SATURATE,
        TK_MUTATED,
        TK_CANON,
        TK_ONES,
        TK_NOISE
    } text_kind_e;

    localparam int NUM_KINDS    = 8;
    localparam int PHASE_CHARS  = 32;
    localparam int SETTLE_TICKS = 12;

    logic       clk = 1'b0;
    logic       rst_n;
    char_beat_t char_beat;
    logic       char_valid;
    logic       char_stall;
    byte_beat_t byte_beat;
    logic       byte_valid;
    logic       byte_stall = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int sent_chars    = 0;
    int n_strings     = 0;
    int n_decoded     = 0;
    int n_rejected    = 0;

    // Predicted decoder state, mirrored one character at a time.
    logic [ACC_W-1:0] acc_value;
    logic [CNT_W-1:0] acc_count;
    logic [CNT_W-1:0] acc_lead;
    logic             acc_leading;
    logic             acc_bad;

    // Byte beats still owed by the decoder, oldest first.
    byte_beat_t pending_bytes[$];

    // The string currently being built for transmission.
    logic [7:0] text_buf[$];

    base58_decode_32_byte_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_beat  (char_beat),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .byte_beat  (byte_beat),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall)
    );

    // 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Safety net: far longer than the slowest correct run with every stall pattern.
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // The receiver holds off at random; the percentage is changed between passes.
    always @(negedge clk)
    begin
        byte_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Returns the prediction to the state the decoder takes after reset and after each string.
    task automatic clear_decoder_state();
        acc_value   = '0;
        acc_count   = '0;
        acc_lead    = '0;
        acc_leading = 1'b1;
        acc_bad     = 1'b0;
    endtask

    // Folds one accepted character into the predicted state. On the last character of a string
    // it settles the four checks and queues either the 32 decoded bytes or a single failure beat.
    task automatic predict_decode(input logic [7:0] c, input logic last);
        int         digit;
        int         zeros;
        logic       ok;
        byte_beat_t beat;
        digit = -1;
        for (int i = 0; i < 58; i++)
        begin
            if (b58_alphabet[i] == c)
                digit = i;
        end
        // A character outside the alphabet still counts towards the length and enters as digit zero.
        if (digit < 0)
        begin
            acc_bad = 1'b1;
            digit   = 0;
        end
        acc_value = acc_value * ACC_W'(58) + ACC_W'(digit);
        if (acc_count != CNT_SAT)
            acc_count = acc_count + 1'b1;
        if (acc_leading && c == CHAR_ONE)
        begin
            if (acc_lead != CNT_SAT)
                acc_lead = acc_lead + 1'b1;
        end
        else
        begin
            acc_leading = 1'b0;
        end
        if (!last)
            return;

        ok = (acc_count >= MIN_COUNT) && (acc_count <= MAX_COUNT) && !acc_bad
             && (acc_value[ACC_W-1:VAL_W] == '0);
        zeros = 0;
        while (zeros < OUT_BYTES && acc_value[VAL_W-1-8*zeros -: 8] == 8'h00)
            zeros++;
        // Canonical form: without leading ones the top byte must be set; with them, each
        // leading one must stand for exactly one leading zero byte.
        if (acc_lead == '0)
        begin
            if (acc_value[VAL_W-1 -: 8] == 8'h00)
                ok = 1'b0;
        end
        else if (int'(acc_lead) != zeros)
        begin
            ok = 1'b0;
        end

        n_strings++;
        if (ok)
        begin
            n_decoded++;
            for (int i = 0; i < OUT_BYTES; i++)
            begin
                beat.data_byte = acc_value[VAL_W-1-8*i -: 8];
                beat.decode_ok = 1'b1;
                beat.byte_last = (i == OUT_BYTES - 1);
                pending_bytes.push_back(beat);
            end
        end
        else
        begin
            n_rejected++;
            beat.data_byte = 8'h00;
            beat.decode_ok = 1'b0;
            beat.byte_last = 1'b1;
            pending_bytes.push_back(beat);
        end
        clear_decoder_state();
    endtask

    // Sends one character beat, with random idle cycles ahead of it, and waits for acceptance.
    // Valid is only ever set once per falling edge, so back-to-back beats keep it high.
    task automatic send_char(input logic [7:0] c, input logic last);
        char_beat_t beat;
        beat.text_char = c;
        beat.char_last = last;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_beat  <= beat;
        char_valid <= 1'b1;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        predict_decode(c, last);
        sent_chars++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Proper Base58 encoding: one '1' per leading zero byte, then the digits of the value.
    task automatic encode_value(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] rest;
        int               zeros;
        text_buf.delete();
        rest  = v;
        zeros = 0;
        while (zeros < OUT_BYTES && v[VAL_W-1-8*zeros -: 8] == 8'h00)
            zeros++;
        while (rest != '0)
        begin
            text_buf.push_front(b58_alphabet[int'(rest % VAL_W'(58))]);
            rest = rest / VAL_W'(58);
        end
        repeat (zeros)
            text_buf.push_front(CHAR_ONE);
    endtask

    task automatic fill_ones(input int count);
        text_buf.delete();
        repeat (count)
            text_buf.push_back(CHAR_ONE);
    endtask

    function automatic logic [7:0] random_digit_char();
        return b58_alphabet[$urandom_range(57)];
    endfunction

    // A random value, mostly full width but now and then with leading zero bytes.
    function automatic logic [VAL_W-1:0] random_value();
        logic [VAL_W-1:0] v;
        int               r;
        int               k;
        v = {$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
        r = $urandom_range(99);
        k = (r < 60) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(0, OUT_BYTES);
        return v >> (8 * k);
    endfunction

    function automatic text_kind_e pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 45)      return TK_CANON;
        else if (r < 60) return TK_MUTATED;
        else if (r < 68) return TK_OVER;
        else if (r < 74) return TK_ONES;
        else if (r < 77) return TK_ZERO;
        else if (r < 80) return TK_MAX;
        else if (r < 83) return TK_SATURATE;
        else             return TK_NOISE;
    endfunction

    // Fills text_buf with one string of the given kind, random in its content.
    task automatic build_text(input text_kind_e kind);
        int p;
        int len;
        case (kind)
            TK_ZERO:
                encode_value('0);
            TK_MAX:
                encode_value('1);
            TK_OVER:
            begin
                // 44 digits led by the top digit always exceed 256 bits.
                text_buf.delete();
                text_buf.push_back(b58_alphabet[57]);
                repeat (MAX_CHARS - 1)
                    text_buf.push_back(random_digit_char());
            end
            TK_SATURATE:
            begin
                // Enough ones to pin both the length and the leading-ones counters.
                fill_ones($urandom_range(64, 72));
                if ($urandom_range(1))
                    text_buf.push_back(random_digit_char());
            end
            TK_ONES:
                fill_ones($urandom_range(1) ? $urandom_range(28, 36) : $urandom_range(1, 70));
            TK_CANON:
                encode_value(random_value());
            TK_MUTATED:
            begin
                // A well-formed string with one defect: a stray byte, an extra or a missing
                // leading character, a changed digit or an extra trailing digit.
                encode_value(random_value());
                p = $urandom_range(text_buf.size() - 1);
                case ($urandom_range(4))
                    0: text_buf[p] = 8'($urandom_range(255));
                    1: text_buf.push_front(CHAR_ONE);
                    2: void'(text_buf.pop_front());
                    3: text_buf[p] = random_digit_char();
                    default: text_buf.push_back(random_digit_char());
                endcase
                if (text_buf.size() == 0)
                    text_buf.push_back(random_digit_char());
            end
            default:
            begin
                // Noise: any byte values mixed with alphabet characters, at lengths from 1 to past the limit.
                text_buf.delete();
                len = $urandom_range(1, 72);
                repeat (len)
                begin
                    if ($urandom_range(1))
                        text_buf.push_back(8'($urandom_range(255)));
                    else
                        text_buf.push_back(random_digit_char());
                end
            end
        endcase
    endtask

    // Short strings that hit the edges of the character field and the gaps in the alphabet;
    // all of them are too short, so each yields a single failure beat.
    task automatic test_edge_characters();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        text_buf = '{8'h00};
        send_text();
        text_buf = '{8'hff};
        send_text();
        text_buf = '{CHAR_ONE};
        send_text();
        text_buf = '{"z", 8'h80, "0", "I", "O", "l", 8'h7f};
        send_text();
        text_buf = '{CHAR_ONE, CHAR_ONE, "2"};
        send_text();
        text_buf = '{8'h30, 8'h3a, 8'h40, 8'h5b, 8'h60, 8'h7b};
        send_text();
        text_buf = '{"A", "H", "J", "N", "P", "Z", "a", "k", "m"};
        send_text();
    endtask

    // Random strings under one stall mix until about PHASE_CHARS characters have gone in.
    task automatic test_random_strings(input int send_pct, input int recv_pct,
                                       input bit force_kinds);
        int         start_chars;
        int         n;
        text_kind_e kind;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_chars   = sent_chars;
        n             = 0;
        while (sent_chars - start_chars < PHASE_CHARS)
        begin
            kind = (force_kinds && n < NUM_KINDS) ? text_kind_e'(n) : pick_kind();
            build_text(kind);
            send_text();
            n++;
        end
    endtask

    // Compares every accepted byte beat with the oldest prediction.
    always @(posedge clk)
    begin : check_bytes
        byte_beat_t want;
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected beat data_byte=%02h decode_ok=%0b byte_last=%0b",
                         $time, byte_beat.data_byte, byte_beat.decode_ok, byte_beat.byte_last);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (byte_beat.data_byte !== want.data_byte)
                begin
                    $display("%0t: data_byte expected %02h, actual %02h",
                             $time, want.data_byte, byte_beat.data_byte);
                    errors++;
                end
                if (byte_beat.decode_ok !== want.decode_ok)
                begin
                    $display("%0t: decode_ok expected %0b, actual %0b",
                             $time, want.decode_ok, byte_beat.decode_ok);
                    errors++;
                end
                if (byte_beat.byte_last !== want.byte_last)
                begin
                    $display("%0t: byte_last expected %0b, actual %0b",
                             $time, want.byte_last, byte_beat.byte_last);
                    errors++;
                end
            end
        end
    end

    // Main sequence: reset, directed edges, then three random passes with different stall mixes.
    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_beat  = '0;
        clear_decoder_state();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_characters();
        test_random_strings(12, 51, 1'b1);
        test_random_strings(51, 12, 1'b0);
        test_random_strings(0, 0, 1'b0);

        @(negedge clk);
        char_valid <= 1'b0;
        recv_idle_pct = 0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        // Keep running past the drain of the predictions, to catch any stray beat.
        repeat (SETTLE_TICKS)
            @(posedge clk);

        $display("Sent %0d characters in %0d strings: %0d decoded, %0d rejected.",
                 sent_chars, n_strings, n_decoded, n_rejected);
        $display("Strings ran under three stall mixes, from edge characters to overflow.");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
